// ===== rtl/viewport_page_coordinate_mapper_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the viewport/page coordinate mapper
// Concurrent checks on clk_i; the reset-gated form is silenced while rst_ni
// is low. Define ASSERT_OFF to drop all of them.
// ----------------------------------------------------------------------------
`ifndef VIEWPORT_PAGE_COORDINATE_MAPPER_DEFINES_SVH
`define VIEWPORT_PAGE_COORDINATE_MAPPER_DEFINES_SVH

`ifndef ASSERT_OFF
`define VPCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define VPCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define VPCM_ASSERT(lbl, prop, msg)
`define VPCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/vpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// vpcm_pkg: shared types and helpers of the coordinate mapper
// Coordinate formats, mode and register codes, lane records, saturation.
// ----------------------------------------------------------------------------
package vpcm_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned ZOOM_W    = 16;
  localparam int unsigned ZOOM_FRAC = 8;
  localparam int unsigned ZOOM_ONE  = 256;
  localparam int unsigned CFG_IDX_W = 3;
  // dividend magnitude: |coord - offset| shifted by the zoom fraction
  localparam int unsigned DIV_W     = COORD_W + 1 + ZOOM_FRAC;
  localparam int unsigned PROD_W    = COORD_W + ZOOM_W + 1;
  localparam int unsigned SAT_W     = DIV_W + 2;
  // input reg, front, divider stages, two back stages, output reg
  localparam int unsigned PIPE_LAT  = DIV_W + 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-2:0]        dim_t;
  typedef logic [ZOOM_W-1:0]         zoom_t;

  typedef enum logic [1:0] {
    MODE_PT_V2P   = 2'd0,
    MODE_PT_P2V   = 2'd1,
    MODE_RECT_V2P = 2'd2,
    MODE_RECT_P2V = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZOOM   = 3'd0,
    CFG_OFF_X  = 3'd1,
    CFG_OFF_Y  = 3'd2,
    CFG_ROT    = 3'd3,
    CFG_PAGE_W = 3'd4,
    CFG_PAGE_H = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    zoom_t  zoom;
    coord_t off_x;
    coord_t off_y;
    rot_e   rot;
    dim_t   page_w;
    dim_t   page_h;
  } cfg_t;

  // one coordinate in flight: divider operand (sign + magnitude) and the
  // rotated, saturated value for the page-to-viewport direction
  typedef struct packed {
    logic             neg;
    logic [DIV_W-1:0] mag;
    coord_t           pre;
  } lane_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } corner_t;

  function automatic zoom_t zoom_eff(input zoom_t z);
    zoom_eff = (z == '0) ? zoom_t'(ZOOM_ONE) : z;
  endfunction

  function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
    coord_t r;
    if (&v[SAT_W-1:COORD_W-1] || ~|v[SAT_W-1:COORD_W-1]) begin
      r = v[COORD_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic is_to_view(input mode_e m);
    is_to_view = (m == MODE_PT_P2V) || (m == MODE_RECT_P2V);
  endfunction

endpackage

// ===== rtl/vpcm_front.sv =====
// ----------------------------------------------------------------------------
// vpcm_front: operand preparation stage
// Offset removal and divider operands for viewport-to-page; rotation and
// saturation for page-to-viewport. One register stage.
// ----------------------------------------------------------------------------
module vpcm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  vpcm_pkg::mode_e           mode_i,
  input  vpcm_pkg::coord_t [1:0]    x_i,
  input  vpcm_pkg::coord_t [1:0]    y_i,
  input  vpcm_pkg::cfg_t            cfg_i,
  output logic                      valid_o,
  output vpcm_pkg::mode_e           mode_o,
  output vpcm_pkg::lane_t [3:0]     lane_o
);

  logic                  valid_q;
  vpcm_pkg::mode_e       mode_q;
  vpcm_pkg::lane_t [3:0] lane_q, lane_d;

  always_comb begin : p_lanes
    logic signed [vpcm_pkg::COORD_W:0]   dx, dy;
    logic signed [vpcm_pkg::COORD_W+1:0] xe, ye, we, he, rx, ry;
    lane_d = '0;
    for (int c = 0; c < 2; c++) begin
      dx = {x_i[c][vpcm_pkg::COORD_W-1], x_i[c]}
         - {cfg_i.off_x[vpcm_pkg::COORD_W-1], cfg_i.off_x};
      dy = {y_i[c][vpcm_pkg::COORD_W-1], y_i[c]}
         - {cfg_i.off_y[vpcm_pkg::COORD_W-1], cfg_i.off_y};
      lane_d[2*c].neg   = dx[vpcm_pkg::COORD_W];
      lane_d[2*c].mag   = {(dx[vpcm_pkg::COORD_W] ? -dx : dx),
                           {vpcm_pkg::ZOOM_FRAC{1'b0}}};
      lane_d[2*c+1].neg = dy[vpcm_pkg::COORD_W];
      lane_d[2*c+1].mag = {(dy[vpcm_pkg::COORD_W] ? -dy : dy),
                           {vpcm_pkg::ZOOM_FRAC{1'b0}}};

      xe = {{2{x_i[c][vpcm_pkg::COORD_W-1]}}, x_i[c]};
      ye = {{2{y_i[c][vpcm_pkg::COORD_W-1]}}, y_i[c]};
      we = {3'b000, cfg_i.page_w};
      he = {3'b000, cfg_i.page_h};
      unique case (cfg_i.rot)
        vpcm_pkg::ROT_90: begin
          rx = he - ye;
          ry = xe;
        end
        vpcm_pkg::ROT_180: begin
          rx = we - xe;
          ry = he - ye;
        end
        vpcm_pkg::ROT_270: begin
          rx = ye;
          ry = we - xe;
        end
        default: begin
          rx = xe;
          ry = ye;
        end
      endcase
      lane_d[2*c].pre   = vpcm_pkg::sat_coord(vpcm_pkg::SAT_W'(rx));
      lane_d[2*c+1].pre = vpcm_pkg::sat_coord(vpcm_pkg::SAT_W'(ry));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_i;
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign lane_o  = lane_q;

endmodule

// ===== rtl/vpcm_divider.sv =====
// ----------------------------------------------------------------------------
// vpcm_divider: pipelined restoring divider, four lanes
// One quotient bit per stage; magnitude field leaves holding the quotient.
// ----------------------------------------------------------------------------
module vpcm_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  vpcm_pkg::mode_e           mode_i,
  input  vpcm_pkg::lane_t [3:0]     lane_i,
  input  vpcm_pkg::zoom_t           divisor_i,
  output logic                      valid_o,
  output vpcm_pkg::mode_e           mode_o,
  output vpcm_pkg::lane_t [3:0]     lane_o
);

  localparam int unsigned NS = vpcm_pkg::DIV_W;

  logic                  valid_q [NS];
  vpcm_pkg::mode_e       mode_q  [NS];
  vpcm_pkg::lane_t [3:0] lane_q  [NS];
  vpcm_pkg::zoom_t [3:0] rem_q   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                  vld_in;
    vpcm_pkg::mode_e       mode_in;
    vpcm_pkg::lane_t [3:0] lane_in, lane_d;
    vpcm_pkg::zoom_t [3:0] rem_in, rem_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign mode_in = mode_i;
      assign lane_in = lane_i;
      assign rem_in  = '0;
    end else begin : g_next
      assign vld_in  = valid_q[k-1];
      assign mode_in = mode_q[k-1];
      assign lane_in = lane_q[k-1];
      assign rem_in  = rem_q[k-1];
    end

    always_comb begin
      logic [vpcm_pkg::ZOOM_W:0] trial;
      lane_d = lane_in;
      rem_d  = rem_in;
      for (int l = 0; l < 4; l++) begin
        trial = {rem_in[l], lane_in[l].mag[NS-1]};
        if (trial >= {1'b0, divisor_i}) begin
          rem_d[l]      = vpcm_pkg::ZOOM_W'(trial - {1'b0, divisor_i});
          lane_d[l].mag = {lane_in[l].mag[NS-2:0], 1'b1};
        end else begin
          rem_d[l]      = trial[vpcm_pkg::ZOOM_W-1:0];
          lane_d[l].mag = {lane_in[l].mag[NS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      mode_q[k] <= mode_in;
      lane_q[k] <= lane_d;
      rem_q[k]  <= rem_d;
    end
  end

  assign valid_o = valid_q[NS-1];
  assign mode_o  = mode_q[NS-1];
  assign lane_o  = lane_q[NS-1];

endmodule

// ===== rtl/vpcm_back.sv =====
// ----------------------------------------------------------------------------
// vpcm_back: finishing stages
// Stage 1: signed quotient and zoom product. Stage 2: rotation or offset,
// then saturation per corner.
// ----------------------------------------------------------------------------
module vpcm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  vpcm_pkg::mode_e           mode_i,
  input  vpcm_pkg::lane_t [3:0]     lane_i,
  input  vpcm_pkg::zoom_t           zoom_i,
  input  vpcm_pkg::cfg_t            cfg_i,
  output logic                      valid_o,
  output vpcm_pkg::mode_e           mode_o,
  output vpcm_pkg::corner_t [1:0]   res_o
);

  logic                                    s1_valid_q;
  vpcm_pkg::mode_e                         s1_mode_q;
  logic signed [vpcm_pkg::SAT_W-1:0]       quot_q [4];
  logic signed [vpcm_pkg::SAT_W-1:0]       quot_d [4];
  logic signed [vpcm_pkg::PROD_W-1:0]      prod_q [4];
  logic signed [vpcm_pkg::PROD_W-1:0]      prod_d [4];

  logic                                    s2_valid_q;
  vpcm_pkg::mode_e                         s2_mode_q;
  vpcm_pkg::corner_t [1:0]                 res_q, res_d;

  always_comb begin : p_stage1
    logic signed [vpcm_pkg::SAT_W-1:0] q;
    for (int l = 0; l < 4; l++) begin
      q         = {2'b00, lane_i[l].mag};
      quot_d[l] = lane_i[l].neg ? -q : q;
      prod_d[l] = lane_i[l].pre * $signed({1'b0, zoom_i});
    end
  end

  always_comb begin : p_stage2
    logic signed [vpcm_pkg::SAT_W-1:0]  ux, uy, vx, vy, px, py, we, he, ox, oy;
    logic signed [vpcm_pkg::PROD_W-1:0] sx, sy;
    we = {{(vpcm_pkg::SAT_W-vpcm_pkg::COORD_W+1){1'b0}}, cfg_i.page_w};
    he = {{(vpcm_pkg::SAT_W-vpcm_pkg::COORD_W+1){1'b0}}, cfg_i.page_h};
    ox = {{(vpcm_pkg::SAT_W-vpcm_pkg::COORD_W){cfg_i.off_x[vpcm_pkg::COORD_W-1]}},
          cfg_i.off_x};
    oy = {{(vpcm_pkg::SAT_W-vpcm_pkg::COORD_W){cfg_i.off_y[vpcm_pkg::COORD_W-1]}},
          cfg_i.off_y};
    res_d = '0;
    for (int c = 0; c < 2; c++) begin
      ux = quot_q[2*c];
      uy = quot_q[2*c+1];
      unique case (cfg_i.rot)
        vpcm_pkg::ROT_90: begin
          vx = uy;
          vy = he - ux;
        end
        vpcm_pkg::ROT_180: begin
          vx = we - ux;
          vy = he - uy;
        end
        vpcm_pkg::ROT_270: begin
          vx = we - uy;
          vy = ux;
        end
        default: begin
          vx = ux;
          vy = uy;
        end
      endcase
      // arithmetic shift rounds toward minus infinity
      sx = prod_q[2*c] >>> vpcm_pkg::ZOOM_FRAC;
      sy = prod_q[2*c+1] >>> vpcm_pkg::ZOOM_FRAC;
      px = sx[vpcm_pkg::SAT_W-1:0] + ox;
      py = sy[vpcm_pkg::SAT_W-1:0] + oy;
      if (vpcm_pkg::is_to_view(s1_mode_q)) begin
        res_d[c].x = vpcm_pkg::sat_coord(px);
        res_d[c].y = vpcm_pkg::sat_coord(py);
      end else begin
        res_d[c].x = vpcm_pkg::sat_coord(vx);
        res_d[c].y = vpcm_pkg::sat_coord(vy);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q <= mode_i;
    quot_q    <= quot_d;
    prod_q    <= prod_d;
    s2_mode_q <= s1_mode_q;
    res_q     <= res_d;
  end

  assign valid_o = s2_valid_q;
  assign mode_o  = s2_mode_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/viewport_page_coordinate_mapper.sv =====
// ----------------------------------------------------------------------------
// viewport_page_coordinate_mapper: viewport <-> page coordinate mapping
// Points or rectangles, signed Q23.8 coordinates, unsigned Q8.8 zoom,
// quarter-turn page rotation. Fully pipelined, one item per cycle while busy_o is low.
// ----------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   -------   ---------------------------------------   ---------
//   command   start_i, busy_o, mode_i, in_{x,y}{0,1}_i  in
//   result    done_o, out_{x,y}{0,1}_o                  out
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i          in
//
// A command transfer happens at a clock edge with start_i high and busy_o
// low. busy_o is high in reset and in the first cycle after it; afterwards one
// command can be taken every cycle. The result passes the input register,
// front stage, 41 divider stages, two finishing stages and the output
// register, and shows up with done_o high for one cycle. The divider
// pipeline works out one quotient bit per stage. The result side never
// stalls, so nothing is held back; reset empties every stage.
//
// Configuration writes take effect at the write edge and must only happen
// while no command is in flight.
// ----------------------------------------------------------------------------
`include "viewport_page_coordinate_mapper_defines.svh"

module viewport_page_coordinate_mapper (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [1:0]                            mode_i,
  input  logic signed [vpcm_pkg::COORD_W-1:0]   in_x0_i,
  input  logic signed [vpcm_pkg::COORD_W-1:0]   in_y0_i,
  input  logic signed [vpcm_pkg::COORD_W-1:0]   in_x1_i,
  input  logic signed [vpcm_pkg::COORD_W-1:0]   in_y1_i,
  // result
  output logic                                  done_o,
  output logic signed [vpcm_pkg::COORD_W-1:0]   out_x0_o,
  output logic signed [vpcm_pkg::COORD_W-1:0]   out_y0_o,
  output logic signed [vpcm_pkg::COORD_W-1:0]   out_x1_o,
  output logic signed [vpcm_pkg::COORD_W-1:0]   out_y1_o,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [vpcm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [vpcm_pkg::COORD_W-1:0]          cfg_wdata_i
);

  logic accept;

  // register file
  vpcm_pkg::cfg_t  cfg_q, cfg_d;
  vpcm_pkg::zoom_t zoom;

  // input register
  logic                   in_valid_q;
  vpcm_pkg::mode_e        in_mode_q;
  vpcm_pkg::coord_t [1:0] in_x_q, in_y_q;

  logic                   busy_q;

  // inter-stage
  logic                    fr_valid, dv_valid, bk_valid;
  vpcm_pkg::mode_e         fr_mode, dv_mode, bk_mode;
  vpcm_pkg::lane_t [3:0]   fr_lane, dv_lane;
  vpcm_pkg::corner_t [1:0] bk_res;

  // output register
  logic                   done_q;
  logic                   out_rect_q;
  vpcm_pkg::coord_t       out_x0_q, out_y0_q, out_x1_q, out_y1_q;
  vpcm_pkg::coord_t       out_x0_d, out_y0_d, out_x1_d, out_y1_d;
  logic                   rect;

  assign accept = start_i && !busy_q;
  assign zoom   = vpcm_pkg::zoom_eff(cfg_q.zoom);

  // ---------------------------------------------------------------------------
  // configuration writes; unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vpcm_pkg::CFG_ZOOM:   cfg_d.zoom   = cfg_wdata_i[vpcm_pkg::ZOOM_W-1:0];
        vpcm_pkg::CFG_OFF_X:  cfg_d.off_x  = cfg_wdata_i;
        vpcm_pkg::CFG_OFF_Y:  cfg_d.off_y  = cfg_wdata_i;
        vpcm_pkg::CFG_ROT:    cfg_d.rot    = vpcm_pkg::rot_e'(cfg_wdata_i[1:0]);
        vpcm_pkg::CFG_PAGE_W: cfg_d.page_w = cfg_wdata_i[vpcm_pkg::COORD_W-2:0];
        vpcm_pkg::CFG_PAGE_H: cfg_d.page_h = cfg_wdata_i[vpcm_pkg::COORD_W-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom   <= vpcm_pkg::zoom_t'(vpcm_pkg::ZOOM_ONE);
      cfg_q.off_x  <= '0;
      cfg_q.off_y  <= '0;
      cfg_q.rot    <= vpcm_pkg::ROT_0;
      cfg_q.page_w <= '0;
      cfg_q.page_h <= '0;
      busy_q       <= 1'b1;
      in_valid_q   <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      busy_q       <= 1'b0;
      in_valid_q   <= accept;
      done_q       <= bk_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // command capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    in_mode_q <= vpcm_pkg::mode_e'(mode_i);
    in_x_q    <= {in_x1_i, in_x0_i};
    in_y_q    <= {in_y1_i, in_y0_i};
  end

  vpcm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .mode_i  (in_mode_q),
    .x_i     (in_x_q),
    .y_i     (in_y_q),
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .mode_o  (fr_mode),
    .lane_o  (fr_lane)
  );

  vpcm_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fr_valid),
    .mode_i    (fr_mode),
    .lane_i    (fr_lane),
    .divisor_i (zoom),
    .valid_o   (dv_valid),
    .mode_o    (dv_mode),
    .lane_o    (dv_lane)
  );

  vpcm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .mode_i  (dv_mode),
    .lane_i  (dv_lane),
    .zoom_i  (zoom),
    .cfg_i   (cfg_q),
    .valid_o (bk_valid),
    .mode_o  (bk_mode),
    .res_o   (bk_res)
  );

  // ---------------------------------------------------------------------------
  // corner ordering: min/max for rectangles, copy for points
  // ---------------------------------------------------------------------------
  assign rect = (bk_mode == vpcm_pkg::MODE_RECT_V2P) ||
                (bk_mode == vpcm_pkg::MODE_RECT_P2V);

  always_comb begin
    if (rect) begin
      out_x0_d = (bk_res[0].x < bk_res[1].x) ? bk_res[0].x : bk_res[1].x;
      out_y0_d = (bk_res[0].y < bk_res[1].y) ? bk_res[0].y : bk_res[1].y;
      out_x1_d = (bk_res[0].x > bk_res[1].x) ? bk_res[0].x : bk_res[1].x;
      out_y1_d = (bk_res[0].y > bk_res[1].y) ? bk_res[0].y : bk_res[1].y;
    end else begin
      out_x0_d = bk_res[0].x;
      out_y0_d = bk_res[0].y;
      out_x1_d = bk_res[0].x;
      out_y1_d = bk_res[0].y;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rect_q <= rect;
    out_x0_q   <= out_x0_d;
    out_y0_q   <= out_y0_d;
    out_x1_q   <= out_x1_d;
    out_y1_q   <= out_y1_d;
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign out_x0_o = out_x0_q;
  assign out_y0_o = out_y0_q;
  assign out_x1_o = out_x1_q;
  assign out_y1_o = out_y1_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `VPCM_ASSERT(a_lat_fwd, accept |-> ##(vpcm_pkg::PIPE_LAT) done_o, "result missing after latency")
  `VPCM_ASSERT(a_lat_back, done_o |-> $past(accept, vpcm_pkg::PIPE_LAT), "result without command")
  `VPCM_ASSERT(a_order, done_o |-> (out_x0_o <= out_x1_o && out_y0_o <= out_y1_o), "corners out of order")
  `VPCM_ASSERT(a_point_copy, (done_o && !out_rect_q) |-> (out_x0_o == out_x1_o && out_y0_o == out_y1_o), "point copy mismatch")
  `VPCM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!done_o && busy_o), "pipeline not flushed in reset")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Coordinate mapper testbench
// Drives point and rectangle commands through all four mapping modes under
// many zoom / offset / rotation / page-size settings, predicts each result
// with a 64-bit behavioral model and checks it field by field in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DRAIN_CYCLES = vpcm_pkg::PIPE_LAT + 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] mode_i = '0;
  logic signed [vpcm_pkg::COORD_W-1:0] in_x0_i = '0, in_y0_i = '0, in_x1_i = '0, in_y1_i = '0;
  logic done_o;
  logic signed [vpcm_pkg::COORD_W-1:0] out_x0_o, out_y0_o, out_x1_o, out_y1_o;
  logic cfg_we_i = 1'b0;
  logic [vpcm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [vpcm_pkg::COORD_W-1:0] cfg_wdata_i = '0;

  viewport_page_coordinate_mapper DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model copy of the register file
  logic [15:0] m_zoom = 16'd256;
  logic signed [31:0] m_off_x = '0, m_off_y = '0;
  logic [1:0] m_rot = vpcm_pkg::ROT_0;
  logic [30:0] m_page_w = '0, m_page_h = '0;

  typedef struct {
    logic signed [31:0] x0, y0, x1, y1;
  } rect_t;

  rect_t mapped_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int mode_hits[4];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint eff_zoom();
    return (m_zoom == 0) ? 64'sd256 : longint'({48'd0, m_zoom});
  endfunction

  // viewport to page: unscroll, unzoom (truncating divide), unrotate
  function automatic void view_to_page(input longint x, input longint y,
                                       output longint ox, output longint oy);
    longint z, ux, uy, w, h;
    z = eff_zoom();
    ux = ((x - longint'(m_off_x)) * 256) / z;
    uy = ((y - longint'(m_off_y)) * 256) / z;
    w = longint'({33'd0, m_page_w});
    h = longint'({33'd0, m_page_h});
    case (m_rot)
      vpcm_pkg::ROT_90:  begin ox = uy;     oy = h - ux; end
      vpcm_pkg::ROT_180: begin ox = w - ux; oy = h - uy; end
      vpcm_pkg::ROT_270: begin ox = w - uy; oy = ux;     end
      default:           begin ox = ux;     oy = uy;     end
    endcase
    ox = clamp32(ox);
    oy = clamp32(oy);
  endfunction

  // page to viewport: rotate (saturated), zoom with floor shift, add offset
  function automatic void page_to_view(input longint x, input longint y,
                                       output longint ox, output longint oy);
    longint z, rx, ry, w, h;
    z = eff_zoom();
    w = longint'({33'd0, m_page_w});
    h = longint'({33'd0, m_page_h});
    case (m_rot)
      vpcm_pkg::ROT_90:  begin rx = h - y; ry = x;     end
      vpcm_pkg::ROT_180: begin rx = w - x; ry = h - y; end
      vpcm_pkg::ROT_270: begin rx = y;     ry = w - x; end
      default:           begin rx = x;     ry = y;     end
    endcase
    rx = clamp32(rx);
    ry = clamp32(ry);
    ox = clamp32(((rx * z) >>> 8) + longint'(m_off_x));
    oy = clamp32(((ry * z) >>> 8) + longint'(m_off_y));
  endfunction

  function automatic rect_t map_item(input logic [1:0] md, input rect_t a);
    longint ax, ay, bx, by;
    rect_t r;
    if (md[0]) page_to_view(a.x0, a.y0, ax, ay);
    else view_to_page(a.x0, a.y0, ax, ay);
    if (md[1]) begin
      if (md[0]) page_to_view(a.x1, a.y1, bx, by);
      else view_to_page(a.x1, a.y1, bx, by);
    end else begin
      bx = ax;
      by = ay;
    end
    r.x0 = 32'((ax < bx) ? ax : bx);
    r.y0 = 32'((ay < by) ? ay : by);
    r.x1 = 32'((ax > bx) ? ax : bx);
    r.y1 = 32'((ay > by) ? ay : by);
    return r;
  endfunction

  // --- result checker: done_o is a one-cycle strobe, sample at the edge ----
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      rect_t e;
      n_results++;
      if (mapped_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result transfer");
      end else begin
        e = mapped_q.pop_front();
        if (out_x0_o !== e.x0 || out_y0_o !== e.y0 ||
            out_x1_o !== e.x1 || out_y1_o !== e.y1) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d exp (%0d,%0d,%0d,%0d) got (%0d,%0d,%0d,%0d)",
                     n_results, e.x0, e.y0, e.x1, e.y1,
                     out_x0_o, out_y0_o, out_x1_o, out_y1_o);
        end
      end
    end
  end

  // --- shared helpers -------------------------------------------------------
  // at least one idle cycle, so start_i is never driven twice in one step
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
    repeat (n) @(posedge clk_i);
  endtask

  // one command transfer; gap_on = 0 gives back-to-back starts
  task automatic send_item(input logic [1:0] md, input rect_t a, input bit gap_on);
    mode_i <= md;
    in_x0_i <= a.x0;
    in_y0_i <= a.y0;
    in_x1_i <= a.x1;
    in_y1_i <= a.y1;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    mapped_q.push_back(map_item(md, a));
    mode_hits[md]++;
    n_items++;
    if (gap_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      idle_gap();
    end
  endtask

  // wait for every expected transfer, then the pipeline depth
  task automatic drain();
    start_i <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write, only while nothing is in flight; the caller drops the enable
  task automatic write_reg(input vpcm_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    n_cfg++;
    case (idx)
      vpcm_pkg::CFG_ZOOM:   m_zoom = val[15:0];
      vpcm_pkg::CFG_OFF_X:  m_off_x = val;
      vpcm_pkg::CFG_OFF_Y:  m_off_y = val;
      vpcm_pkg::CFG_ROT:    m_rot = val[1:0];
      vpcm_pkg::CFG_PAGE_W: m_page_w = val[30:0];
      vpcm_pkg::CFG_PAGE_H: m_page_h = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [15:0] z, input logic [31:0] ox, input logic [31:0] oy,
                         input logic [1:0] r, input logic [30:0] w, input logic [30:0] h);
    write_reg(vpcm_pkg::CFG_ZOOM, {16'd0, z});
    write_reg(vpcm_pkg::CFG_OFF_X, ox);
    write_reg(vpcm_pkg::CFG_OFF_Y, oy);
    write_reg(vpcm_pkg::CFG_ROT, {30'd0, r});
    write_reg(vpcm_pkg::CFG_PAGE_W, {1'b0, w});
    write_reg(vpcm_pkg::CFG_PAGE_H, {1'b0, h});
    cfg_we_i <= 1'b0;
  endtask

  // coordinates: mostly moderate page-like values, sometimes full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom_range(0, 400000)) - 100000;
    endcase
  endfunction

  function automatic rect_t rand_rect();
    rect_t r;
    r.x0 = rand_coord();
    r.y0 = rand_coord();
    r.x1 = rand_coord();
    r.y1 = rand_coord();
    return r;
  endfunction

  function automatic logic [15:0] rand_zoom();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 3) == 0 ? 16'd0 : 16'hffff;
      1: return 16'($urandom);
      default: return 16'($urandom_range(32, 1024));
    endcase
  endfunction

  // --- test tasks -----------------------------------------------------------
  // field extremes at reset values, every mode, zero zoom, all rotations
  task automatic test_directed();
    rect_t a;
    logic [31:0] ext[4];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    for (int m = 0; m < 4; m++) begin
      a.x0 = ext[m]; a.y0 = ext[3 - m]; a.x1 = ext[(m + 1) % 4]; a.y1 = ext[(m + 2) % 4];
      send_item(m[1:0], a, 1'b0);
    end
    drain();
    // extreme config: max zoom, most negative x offset, most positive y offset, max page, 90 deg
    set_all(16'hffff, 32'h8000_0000, 32'h7fff_ffff, vpcm_pkg::ROT_90,
            31'h7fff_ffff, 31'h7fff_ffff);
    for (int m = 0; m < 4; m++) begin
      a.x0 = ext[m]; a.y0 = ext[(m + 3) % 4]; a.x1 = 32'sd1000; a.y1 = -32'sd1000;
      send_item(m[1:0], a, 1'b0);
    end
    drain();
    // zoom written as zero behaves as 1.0; truncation vs floor on negatives
    set_all(16'd0, 32'sd300, -32'sd77, vpcm_pkg::ROT_180, 31'd5000, 31'd7000);
    for (int m = 0; m < 4; m++) begin
      a.x0 = -32'sd1; a.y0 = -32'sd255; a.x1 = 32'sd257; a.y1 = -32'sd3;
      send_item(m[1:0], a, 1'b0);
    end
    drain();
    set_all(16'd3, 32'sd0, 32'sd0, vpcm_pkg::ROT_270, 31'd1, 31'd0);
    for (int m = 0; m < 4; m++) begin
      a.x0 = -32'sd7; a.y0 = 32'sd7; a.x1 = -32'sd1; a.y1 = 32'sd1;
      send_item(m[1:0], a, 1'b0);
    end
    drain();
  endtask

  // random phases, each with its own register setting
  task automatic test_random(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_all(rand_zoom(), rand_coord(), rand_coord(), 2'($urandom_range(0, 3)),
              31'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 300000)),
              31'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 300000)));
      for (int i = 0; i < per_phase; i++)
        send_item(2'($urandom_range(0, 3)), rand_rect(), p % 3 != 0);
      drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(32, 50);
    $display("covered %0d commands (modes %0d/%0d/%0d/%0d), %0d results, %0d register writes",
             n_items, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             n_results, n_cfg);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== viewport_page_coordinate_mapper.f =====
+incdir+rtl
rtl/vpcm_pkg.sv
rtl/vpcm_front.sv
rtl/vpcm_divider.sv
rtl/vpcm_back.sv
rtl/viewport_page_coordinate_mapper.sv
tb/testbench.sv
